// ===== design/dq_pkg.sv =====
// Shared types and codes for the double-ended queue block.
// Used by dq_ctrl, dq_datapath and double_ended_queue_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DATA_W = 32;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;

    // Action codes carried on the input tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_REAR  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } action_t;

    // Result status codes carried on the output tuser
    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_DENIED = 2'd3
    } status_t;

    // Deque discipline
    typedef enum logic {
        MODE_IN_RESTRICT  = 1'b0,
        MODE_OUT_RESTRICT = 1'b1
    } mode_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic execute;   // decide, update pointers, access storage
        logic load;      // move the result into the output register
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_busy;  // output register holds an item not taken this cycle
    } ctrl_stat_t;

endpackage : dq_pkg

`default_nettype wire

// ===== design/dq_ctrl.sv =====
// Sequencing controller for the double-ended queue.
// Depends on dq_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  dq_pkg::ctrl_stat_t  stat,
    output dq_pkg::ctrl_cmd_t   cmd
);

    dq_pkg::state_t state_reg;
    dq_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dq_pkg::ST_EXEC;
                end
            end
            dq_pkg::ST_EXEC:
            begin
                state_next = dq_pkg::ST_LOAD;
            end
            dq_pkg::ST_LOAD:
            begin
                if (!stat.out_busy)
                begin
                    state_next = dq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            dq_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            dq_pkg::ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            dq_pkg::ST_LOAD:
            begin
                cmd.load = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule : dq_ctrl

`default_nettype wire

// ===== design/dq_datapath.sv =====
// Datapath of the double-ended queue: ring storage, head and count pointers,
// mode register and output register. Depends on dq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dq_datapath #(
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int SW = AW + 1
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  dq_pkg::ctrl_cmd_t            cmd,
    output dq_pkg::ctrl_stat_t           stat,
    input  wire                          cfg_we,
    input  wire                          cfg_wdata,
    input  dq_pkg::action_t              in_action,
    input  wire [dq_pkg::DATA_W-1:0]     in_value,
    input  wire                          out_ready,
    output logic                         out_valid,
    output logic [dq_pkg::DATA_W-1:0]    out_value,
    output dq_pkg::status_t              out_status,
    output logic [CW-1:0]                out_occ
);

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [SW-1:0] RING_SIZE  = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);

    // Storage
    logic [dq_pkg::DATA_W-1:0] mem [DEPTH];

    // Captured item
    dq_pkg::action_t           action_reg;
    logic [dq_pkg::DATA_W-1:0] value_reg;

    // Control state
    dq_pkg::mode_t  mode_reg;
    logic [AW-1:0]  head_reg;
    logic [AW-1:0]  head_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           out_valid_reg;

    // Execute results held for the load step
    dq_pkg::status_t           status_reg;
    logic                      pop_ok_reg;
    logic [dq_pkg::DATA_W-1:0] rd_data_reg;

    // Output register payload
    logic [dq_pkg::DATA_W-1:0] out_value_reg;
    dq_pkg::status_t           out_status_reg;
    logic [CW-1:0]             out_occ_reg;

    // Decision and addressing
    logic            allowed;
    logic            is_push;
    logic            op_ok;
    dq_pkg::status_t status_next;
    logic [CW-1:0]   offset;
    logic [SW-1:0]   ring_sum;
    logic [SW-1:0]   ring_wrap;
    logic [AW-1:0]   ring_pos;
    logic [AW-1:0]   head_dec;
    logic [AW-1:0]   head_inc;
    logic [AW-1:0]   access_addr;

    // Mode check comes before the empty and full checks
    always_comb
    begin
        if (mode_reg == dq_pkg::MODE_IN_RESTRICT)
        begin
            allowed = (action_reg != dq_pkg::ACT_PUSH_FRONT);
        end
        else
        begin
            allowed = (action_reg != dq_pkg::ACT_POP_REAR);
        end
        is_push = (action_reg == dq_pkg::ACT_PUSH_REAR) ||
                  (action_reg == dq_pkg::ACT_PUSH_FRONT);

        priority if (!allowed)
        begin
            status_next = dq_pkg::STAT_DENIED;
        end
        else if (is_push && (count_reg == FULL_COUNT))
        begin
            status_next = dq_pkg::STAT_FULL;
        end
        else if (!is_push && (count_reg == '0))
        begin
            status_next = dq_pkg::STAT_EMPTY;
        end
        else
        begin
            status_next = dq_pkg::STAT_OK;
        end
        op_ok = (status_next == dq_pkg::STAT_OK);
    end

    // Ring position of the rear slot: head plus an offset below 2*DEPTH
    always_comb
    begin
        unique case (action_reg)
            dq_pkg::ACT_PUSH_REAR:  offset = count_reg;
            dq_pkg::ACT_POP_REAR:   offset = count_reg - CW'(1);
            default:                offset = '0;
        endcase
        ring_sum  = SW'(head_reg) + SW'(offset);
        ring_wrap = (ring_sum >= RING_SIZE) ? (ring_sum - RING_SIZE) : ring_sum;
        ring_pos  = ring_wrap[AW-1:0];
        head_dec  = (head_reg == '0) ? LAST_INDEX : (head_reg - AW'(1));
        head_inc  = (head_reg == LAST_INDEX) ? '0 : (head_reg + AW'(1));
    end

    // Storage address, pointer updates
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        unique case (action_reg)
            dq_pkg::ACT_PUSH_FRONT: access_addr = head_dec;
            dq_pkg::ACT_POP_FRONT:  access_addr = head_reg;
            default:                access_addr = ring_pos;
        endcase
        if (cmd.execute && op_ok)
        begin
            if (is_push)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                count_next = count_reg - CW'(1);
            end
            if (action_reg == dq_pkg::ACT_PUSH_FRONT)
            begin
                head_next = head_dec;
            end
            else if (action_reg == dq_pkg::ACT_POP_FRONT)
            begin
                head_next = head_inc;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= dq_pkg::MODE_IN_RESTRICT;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= dq_pkg::mode_t'(cfg_wdata);
            end
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= in_action;
            value_reg  <= in_value;
        end
        if (cmd.execute)
        begin
            status_reg <= status_next;
            pop_ok_reg <= op_ok && !is_push;
        end
        if (cmd.load)
        begin
            out_value_reg  <= pop_ok_reg ? rd_data_reg : '0;
            out_status_reg <= status_reg;
            out_occ_reg    <= count_reg;
        end
    end

    // Ring storage: a write for a successful push, and a registered read on every item
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            if (op_ok && is_push)
            begin
                mem[access_addr] <= value_reg;
            end
            rd_data_reg <= mem[access_addr];
        end
    end

    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_status    = out_status_reg;
    assign out_occ       = out_occ_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= LAST_INDEX)
        else $error("head index outside ring");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && op_ok && is_push) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("successful push did not grow the queue");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && !op_ok) |=> ($stable(head_reg) && $stable(count_reg)))
        else $error("rejected action changed queue state");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(out_valid_reg && !out_ready))
        else $error("result loaded over an item not yet taken");

endmodule : dq_datapath

`default_nettype wire

// ===== design/double_ended_queue_top.sv =====
// A result becomes valid once its item has passed the execute and load states.
// Items are taken one at a time: capture, execute with one storage access and a
// registered read, then load, held while an untaken result waits on m_tready.
// The output register frees the input side once its item is loaded.
// Reset (rst_n low, asynchronous): queue empty, head 0, input-restricted mode,
// no result pending. Storage contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_top #(
    parameter int DEPTH = 16,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OBITS = dq_pkg::DATA_W + CW,
    localparam int OW    = ((OBITS + 7) / 8) * 8
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    // Configuration: restrict_mode
    input  wire                           cfg_we,
    input  wire                           cfg_wdata,
    // Input items
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [dq_pkg::DATA_W-1:0]      s_tdata,   // [31:0] push_value
    input  wire [dq_pkg::ACT_W-1:0]       s_tuser,   // [1:0] action
    // Result items
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [OW-1:0]                 m_tdata,   // [31:0] pop_value, then occupancy
    output logic [dq_pkg::STAT_W-1:0]     m_tuser    // [1:0] status
);

    dq_pkg::ctrl_cmd_t         cmd;
    dq_pkg::ctrl_stat_t        stat;
    logic [dq_pkg::DATA_W-1:0] out_value;
    dq_pkg::status_t           out_status;
    logic [CW-1:0]             out_occ;

    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_action  (dq_pkg::action_t'(s_tuser)),
        .in_value   (s_tdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_value  (out_value),
        .out_status (out_status),
        .out_occ    (out_occ)
    );

    // Pack result fields, zero-filled to whole bytes
    assign m_tdata = OW'({out_occ, out_value});
    assign m_tuser = out_status;

endmodule : double_ended_queue_top

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for double_ended_queue_top: directed and random actions in both modes.
// Depends on dq_pkg and the design files; predicts every result in a small scoreboard class.
`timescale 1ns / 1ps

module tb_top;
    import dq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int OW          = ((DATA_W + CW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;
    localparam int HOLD_AT     = 470;   // results seen before the long receiver hold
    localparam int HOLD_CYCLES = 120;

    // Expected contents of one result item
    typedef struct {
        logic [DATA_W-1:0] pop_value;
        status_t           status;
        logic [CW-1:0]     occupancy;
    } deque_result_t;

    // Predicts each result from the action stream and checks the block against it
    class deque_checker;
        mode_t             mode = MODE_IN_RESTRICT;
        logic [DATA_W-1:0] slots [DEPTH];
        int unsigned       head = 0;
        int unsigned       count = 0;
        deque_result_t     pending_results [$];
        int                errors = 0;
        int                checked = 0;
        int                status_seen [4] = '{0, 0, 0, 0};

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted action to the shadow ring and queue its result
        function void note_action(action_t act, logic [DATA_W-1:0] value);
            deque_result_t r;
            bit            allowed;
            r.pop_value = '0;
            r.status    = STAT_OK;
            allowed = (mode == MODE_IN_RESTRICT) ? (act != ACT_PUSH_FRONT)
                                                 : (act != ACT_POP_REAR);
            if (!allowed) begin
                r.status = STAT_DENIED;
            end else if (act == ACT_PUSH_REAR || act == ACT_PUSH_FRONT) begin
                if (count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else if (act == ACT_PUSH_REAR) begin
                    slots[(head + count) % DEPTH] = value;
                    count++;
                end else begin
                    head = (head + DEPTH - 1) % DEPTH;
                    slots[head] = value;
                    count++;
                end
            end else begin
                if (count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (act == ACT_POP_FRONT) begin
                    r.pop_value = slots[head];
                    head = (head + 1) % DEPTH;
                    count--;
                end else begin
                    r.pop_value = slots[(head + count - 1) % DEPTH];
                    count--;
                end
            end
            r.occupancy = CW'(count);
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [OW-1:0] data, logic [STAT_W-1:0] stat);
            deque_result_t r;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, data %h status %0d", $time, data, stat);
                errors++;
                return;
            end
            r = pending_results.pop_front();
            checked++;
            status_seen[r.status]++;
            if (data[DATA_W-1:0] !== r.pop_value) begin
                $display("%0t: pop_value expected %h got %h", $time, r.pop_value,
                         data[DATA_W-1:0]);
                errors++;
            end
            if (stat !== r.status) begin
                $display("%0t: status expected %0d got %0d", $time, r.status, stat);
                errors++;
            end
            if (data[DATA_W +: CW] !== r.occupancy) begin
                $display("%0t: occupancy expected %0d got %0d", $time, r.occupancy,
                         data[DATA_W +: CW]);
                errors++;
            end
            if (data[OW-1:DATA_W+CW] !== '0) begin
                $display("%0t: tdata padding expected 0 got %h", $time,
                         data[OW-1:DATA_W+CW]);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;   // [31:0] push_value
    logic [ACT_W-1:0]    s_tuser;   // [1:0] action
    logic                m_tvalid;
    logic                m_tready;
    logic [OW-1:0]       m_tdata;   // [31:0] pop_value, [36:32] occupancy
    logic [STAT_W-1:0]   m_tuser;   // [1:0] status

    deque_checker sb;
    bit           quiet;            // no random gaps or stalls drawn while set
    int           items_sent;
    int           mode_writes;
    int           results_seen;
    int           cycle_count;

    double_ended_queue_top #(.DEPTH(DEPTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock, 12 ns period
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Mostly short idle stretches, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Push values lean on the extremes now and then
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly actions legal in the mode, biased toward push or pop
    function automatic action_t pick_action(int push_pct, mode_t m);
        if ($urandom_range(99) < 8)
            return (m == MODE_IN_RESTRICT) ? ACT_PUSH_FRONT : ACT_POP_REAR;
        if ($urandom_range(99) < push_pct) begin
            if (m == MODE_IN_RESTRICT)
                return ACT_PUSH_REAR;
            return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        end
        if (m == MODE_OUT_RESTRICT)
            return ACT_POP_FRONT;
        return $urandom_range(1) ? ACT_POP_REAR : ACT_POP_FRONT;
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(action_t act, logic [DATA_W-1:0] value);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        sb.note_action(act, value);
        items_sent++;
    endtask

    task automatic sender_idle(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    // Drain everything, let the pipeline settle, then write the mode register
    task automatic write_mode(mode_t m);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.mode = m;
        mode_writes++;
    endtask

    // Result side: random stalls, one long hold, check every accepted item
    initial
    begin
        int  stall_left;
        bit  hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = idle_len();
            end
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
                results_seen++;
            end
        end
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        sb           = new;
        quiet        = 1'b1;
        items_sent   = 0;
        mode_writes  = 0;
        results_seen = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = ACT_PUSH_REAR;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Input-restricted after reset: empty pops, denied front push, extremes
        send_item(ACT_POP_FRONT,  32'h1111_1111);
        send_item(ACT_POP_REAR,   32'h2222_2222);
        send_item(ACT_PUSH_FRONT, 32'h3333_3333);
        send_item(ACT_PUSH_REAR,  32'h7FFF_FFFF);
        send_item(ACT_PUSH_REAR,  32'h8000_0000);
        send_item(ACT_PUSH_REAR,  32'hFFFF_FFFF);
        send_item(ACT_PUSH_REAR,  32'h0000_0000);
        send_item(ACT_POP_REAR,   32'h0);
        send_item(ACT_POP_FRONT,  32'h0);
        send_item(ACT_POP_REAR,   32'h0);
        send_item(ACT_POP_FRONT,  32'h0);

        // Output-restricted: denied rear pop, front pushes step the head down to 0
        write_mode(MODE_OUT_RESTRICT);
        send_item(ACT_POP_REAR,   32'h0);
        send_item(ACT_PUSH_FRONT, 32'hA5A5_A5A5);
        send_item(ACT_PUSH_FRONT, 32'h5A5A_5A5A);
        send_item(ACT_PUSH_REAR,  32'h1234_5678);
        repeat (4) send_item(ACT_POP_FRONT, 32'h0);

        // Random phases: fill-heavy, drain-heavy and balanced in both modes
        for (int phase = 0; phase < PHASES; phase++)
        begin
            int push_pct;
            push_pct = (phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 20 : 50;
            write_mode(mode_t'(phase % 2));
            quiet = (phase == 4 || phase == 9);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                sender_idle(idle_len());
                send_item(pick_action(push_pct, sb.mode), pick_value());
            end
        end
        quiet = 1'b0;

        // Wind down and report
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d actions over %0d mode writes, %0d results checked",
                 items_sent, mode_writes, sb.checked);
        $display("Results by status ok/empty/full/denied: %0d/%0d/%0d/%0d",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY],
                 sb.status_seen[STAT_FULL], sb.status_seen[STAT_DENIED]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d errors, %0d results missing", sb.errors, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dq_pkg.sv
design/dq_ctrl.sv
design/dq_datapath.sv
design/double_ended_queue_top.sv
tb/tb_top.sv
